// File: hdl/ssfl_pkg.sv
// Shared types and constants for the sorted symbol table floor lookup.
// No dependencies; imported by every module of the block.
package ssfl_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] addr;
        logic [15:0] name_handle;
    } ssfl_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] hit_addr;
        logic [15:0] hit_name;
    } ssfl_res_t;

    typedef enum logic [1:0] {
        RD_MID   = 2'd0,
        RD_FETCH = 2'd1,
        RD_SHIFT = 2'd2
    } ssfl_rd_sel_t;

    typedef struct packed {
        logic         cap;
        logic         rd_en;
        ssfl_rd_sel_t rd_sel;
        logic         step;
        logic         set_ptr;
        logic         shift_wr;
        logic         ins_wr;
        logic         set_res;
        logic [2:0]   res_status;
        logic         res_hit;
        logic         out_load;
    } ssfl_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic cmp_eq;
        logic req_find;
        logic exact;
        logic pos_zero;
        logic full;
        logic shift_last;
        logic need_shift;
        logic out_free;
    } ssfl_sts_t;

endpackage

// File: hdl/ssfl_dp.sv
// Datapath: entry memory, search bounds, shift pointer, count and result registers.
// Depends on ssfl_pkg; driven by ssfl_ctrl through ssfl_cmd_t.
module ssfl_dp import ssfl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  ssfl_req_t s_data,
    input  logic      m_ready,
    input  ssfl_cmd_t cmd,
    output ssfl_sts_t sts,
    output logic      m_valid,
    output ssfl_res_t m_data
);

    logic [31:0]      mem [CAPACITY];
    logic [31:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;

    ssfl_req_t        req_reg;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg;
    logic             exact_reg, exact_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    ssfl_res_t        res_reg;
    ssfl_res_t        m_data_reg;
    logic             m_valid_reg, m_valid_next;

    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [CNT_W-1:0] pos;
    logic [15:0]      rd_key;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign pos     = exact_reg ? CNT_W'(mid_reg) : lo_reg;
    assign rd_key  = rd_data_reg[31:16];

    always_comb begin
        case (cmd.rd_sel)
            RD_MID:   rd_addr = mid;
            // floor of a miss is the entry just below the insertion point
            RD_FETCH: rd_addr = exact_reg ? mid_reg : IDX_W'(lo_reg - CNT_W'(1));
            RD_SHIFT: rd_addr = IDX_W'(ptr_reg - CNT_W'(1));
            default:  rd_addr = mid;
        endcase
    end

    assign wr_en   = cmd.shift_wr | cmd.ins_wr;
    assign wr_addr = cmd.ins_wr ? IDX_W'(pos) : IDX_W'(ptr_reg);
    assign wr_data = cmd.ins_wr ? {req_reg.addr, req_reg.name_handle} : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        exact_next = exact_reg;
        if (cmd.cap) begin
            lo_next    = '0;
            hi_next    = count_reg;
            exact_next = 1'b0;
        end else if (cmd.step) begin
            if (rd_key == req_reg.addr) begin
                exact_next = 1'b1;
            end else if (rd_key > req_reg.addr) begin
                hi_next = CNT_W'(mid_reg);
            end else begin
                lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            end
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.set_ptr) begin
            ptr_next = count_reg;
        end else if (cmd.shift_wr) begin
            ptr_next = ptr_reg - CNT_W'(1);
        end
    end

    assign count_next = cmd.ins_wr ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            req_reg <= s_data;
        end
        if (cmd.rd_en && cmd.rd_sel == RD_MID) begin
            mid_reg <= mid;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        exact_reg <= exact_next;
        ptr_reg   <= ptr_next;
        if (cmd.set_res) begin
            res_reg.status   <= cmd.res_status;
            res_reg.hit_addr <= cmd.res_hit ? rd_data_reg[31:16] : 16'd0;
            res_reg.hit_name <= cmd.res_hit ? rd_data_reg[15:0] : 16'd0;
        end
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign sts.lo_lt_hi   = lo_reg < hi_reg;
    assign sts.cmp_eq     = rd_key == req_reg.addr;
    assign sts.req_find   = req_reg.req_type == REQ_FIND;
    assign sts.exact      = exact_reg;
    assign sts.pos_zero   = pos == '0;
    assign sts.full       = count_reg == CNT_W'(CAPACITY);
    assign sts.shift_last = (ptr_reg - CNT_W'(1)) == pos;
    assign sts.need_shift = count_reg != pos;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/ssfl_ctrl.sv
// Controller: sequences search probes, entry shifting, insert and result handoff.
// Depends on ssfl_pkg; commands ssfl_dp.
module ssfl_ctrl import ssfl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ssfl_sts_t sts,
    output ssfl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SEARCH   = 9'b000000010,
        S_PROBE    = 9'b000000100,
        S_RESOLVE  = 9'b000001000,
        S_FETCH    = 9'b000010000,
        S_SHIFT_RD = 9'b000100000,
        S_SHIFT_WR = 9'b001000000,
        S_INSERT   = 9'b010000000,
        S_OUT      = 9'b100000000
    } ssfl_state_t;

    ssfl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_MID;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (sts.lo_lt_hi) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = S_PROBE;
                end else begin
                    state_next = S_RESOLVE;
                end
            end
            S_PROBE: begin
                cmd.step   = 1'b1;
                state_next = sts.cmp_eq ? S_RESOLVE : S_SEARCH;
            end
            S_RESOLVE: begin
                if (sts.req_find) begin
                    if (!sts.exact && sts.pos_zero) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_NOTFOUND;
                        state_next     = S_OUT;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_FETCH;
                        state_next = S_FETCH;
                    end
                end else if (sts.exact) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_DUPLICATE;
                    state_next     = S_OUT;
                end else if (sts.full) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_OUT;
                end else begin
                    cmd.set_ptr = 1'b1;
                    state_next  = sts.need_shift ? S_SHIFT_RD : S_INSERT;
                end
            end
            S_FETCH: begin
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_FOUND;
                cmd.res_hit    = 1'b1;
                state_next     = S_OUT;
            end
            S_SHIFT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SHIFT;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = sts.shift_last ? S_INSERT : S_SHIFT_RD;
            end
            S_INSERT: begin
                cmd.ins_wr     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_INSERTED;
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

// File: hdl/sorted_symbol_table_floor_lookup.sv
// Top level of the sorted symbol table floor lookup.
// Depends on ssfl_pkg, ssfl_ctrl and ssfl_dp.
//
// Usage:
//   s_ channel carries one request (add address with name handle, or find
//   the floor entry of an address); m_ channel returns one result per
//   request, in request order.
//   Requests are handled one at a time. Each binary search probe reads the
//   entry memory, then compares the key (S_SEARCH, S_PROBE); a miss ends
//   with a closing bound check in S_SEARCH. A find then fetches the floor
//   entry (read issued in S_RESOLVE, captured by S_FETCH).
//   An insert shifts every entry above its slot, one read and one write
//   per moved entry (S_SHIFT_RD, S_SHIFT_WR) on the entry memory.
//   The result register frees the controller: a new request is taken while
//   the previous result still waits on m_ready. If the receiver stalls with
//   a result already waiting, the next result holds the controller until
//   the output register frees.
//   Reset empties the table at once (count to zero); the entry memory is
//   not cleared and needs no sweep.
module sorted_symbol_table_floor_lookup import ssfl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ssfl_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ssfl_res_t m_data
);

    ssfl_cmd_t cmd;
    ssfl_sts_t sts;

    ssfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ssfl_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// File: hdl/ssfl_chk.sv
// Port-level checker for the sorted symbol table floor lookup, with its bind.
// Depends on ssfl_pkg.
module ssfl_chk import ssfl_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input ssfl_req_t s_data,
    input logic      m_valid,
    input logic      m_ready,
    input ssfl_res_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request at a time: accepting closes the input side
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_INSERTED || m_data.status == ST_DUPLICATE ||
                     m_data.status == ST_FULL || m_data.status == ST_FOUND ||
                     m_data.status == ST_NOTFOUND))
        else $error("bad status code");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_FOUND |-> m_data.hit_addr == 16'd0 &&
        m_data.hit_name == 16'd0)
        else $error("hit fields set without a hit");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind sorted_symbol_table_floor_lookup ssfl_chk u_ssfl_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
